/* rtl/dfr_pkg.sv */
`timescale 1ns / 1ps
`default_nettype none

package dfr_pkg;

  // frame length at which a frame is aborted
  localparam int unsigned MAX_FRAME = 192;

  // framing bytes
  localparam logic [7:0] BYTE_STX = 8'd2;
  localparam logic [7:0] BYTE_ETX = 8'd3;
  localparam logic [7:0] BYTE_DLE = 8'd16;

  // result kinds
  typedef enum logic [1:0] {
    KIND_PAYLOAD = 2'd0,
    KIND_END     = 2'd1,
    KIND_ABORT   = 2'd2
  } dfr_kind_t;

  // one result item
  typedef struct packed {
    dfr_kind_t  kind;
    logic [7:0] data;
    logic [7:0] pos;
  } dfr_result_t;

endpackage

`default_nettype wire

/* rtl/dfr_in_stage.sv */
`timescale 1ns / 1ps
`default_nettype none

module dfr_in_stage
  import dfr_pkg::*;
(
  input  wire logic       clk,
  input  wire logic       rst_n,
  input  wire logic       in_valid,
  output logic            in_ready,
  input  wire logic [7:0] in_rx_byte,
  input  wire logic       take,
  output logic            s1_valid,
  output logic [7:0]      s1_byte
);

  logic       valid_r;
  logic [7:0] byte_r;

  // accept when empty or when the held item moves on this cycle
  assign in_ready = !valid_r || take;
  assign s1_valid = valid_r;
  assign s1_byte  = byte_r;

  // valid flag
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r <= 1'b0;
    end else if (in_valid && in_ready) begin
      valid_r <= 1'b1;
    end else if (take) begin
      valid_r <= 1'b0;
    end
  end

  // byte holding register
  always_ff @(posedge clk) begin
    if (in_valid && in_ready) begin
      byte_r <= in_rx_byte;
    end
  end

endmodule

`default_nettype wire

/* rtl/dfr_decoder.sv */
`timescale 1ns / 1ps
`default_nettype none

module dfr_decoder
  import dfr_pkg::*;
(
  input  wire logic       clk,
  input  wire logic       rst_n,
  input  wire logic       s1_valid,
  input  wire logic [7:0] s1_byte,
  input  wire logic       out_free,
  output logic            take,
  output logic            res_valid,
  output dfr_result_t     res
);

  logic       esc_r, esc_nxt;
  logic       rcv_r, rcv_nxt;
  logic [7:0] cnt_r, cnt_nxt;
  logic       emit;
  logic       take_pl;
  logic [8:0] cnt_inc;

  assign cnt_inc = {1'b0, cnt_r} + 9'd1;

  // per-byte framing decisions
  always_comb begin
    esc_nxt  = esc_r;
    rcv_nxt  = rcv_r;
    cnt_nxt  = cnt_r;
    emit     = 1'b0;
    take_pl  = 1'b0;
    res.kind = KIND_PAYLOAD;
    res.data = s1_byte;
    res.pos  = cnt_r;
    if (esc_r) begin
      esc_nxt = 1'b0;
      case (s1_byte)
        BYTE_STX: begin
          cnt_nxt = '0;
          rcv_nxt = 1'b1;
        end
        BYTE_ETX: begin
          rcv_nxt  = 1'b0;
          emit     = 1'b1;
          res.kind = KIND_END;
          res.data = '0;
        end
        BYTE_DLE: begin
          take_pl = 1'b1;
        end
        default: begin
          // unknown escape is dropped
        end
      endcase
    end else if (s1_byte == BYTE_DLE) begin
      esc_nxt = 1'b1;
    end else begin
      take_pl = 1'b1;
    end
    // payload byte, with overflow abort at the last slot
    if (take_pl && rcv_r) begin
      emit = 1'b1;
      if (cnt_inc >= 9'(MAX_FRAME)) begin
        cnt_nxt  = '0;
        rcv_nxt  = 1'b0;
        res.kind = KIND_ABORT;
      end else begin
        cnt_nxt = cnt_inc[7:0];
      end
    end
  end

  // item moves on when it makes no result or the result register has room
  assign take      = s1_valid && (!emit || out_free);
  assign res_valid = take && emit;

  // frame state
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      esc_r <= 1'b0;
      rcv_r <= 1'b0;
      cnt_r <= '0;
    end else if (take) begin
      esc_r <= esc_nxt;
      rcv_r <= rcv_nxt;
      cnt_r <= cnt_nxt;
    end
  end

endmodule

`default_nettype wire

/* rtl/dfr_out_reg.sv */
`timescale 1ns / 1ps
`default_nettype none

module dfr_out_reg
  import dfr_pkg::*;
(
  input  wire logic        clk,
  input  wire logic        rst_n,
  input  wire logic        res_valid,
  input  wire dfr_result_t res,
  output logic             out_free,
  output logic             out_valid,
  input  wire logic        out_ready,
  output logic [1:0]       out_event_kind,
  output logic [7:0]       out_payload_byte,
  output logic [7:0]       out_position
);

  logic        valid_r;
  dfr_result_t res_r;

  assign out_free         = !valid_r || out_ready;
  assign out_valid        = valid_r;
  assign out_event_kind   = res_r.kind;
  assign out_payload_byte = res_r.data;
  assign out_position     = res_r.pos;

  // result valid flag
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r <= 1'b0;
    end else if (res_valid) begin
      valid_r <= 1'b1;
    end else if (out_ready) begin
      valid_r <= 1'b0;
    end
  end

  // result payload
  always_ff @(posedge clk) begin
    if (res_valid) begin
      res_r <= res;
    end
  end

endmodule

`default_nettype wire

/* rtl/dle_frame_receiver_top.sv */
`timescale 1ns / 1ps
`default_nettype none

// channel   handshake              payload
// input     in_valid / in_ready    in_rx_byte
// result    out_valid / out_ready  out_event_kind, out_payload_byte, out_position
//
// one byte per cycle unless a result stalls; a byte is held in the input
// register and decoded there; its result, if any, goes to the result register
// throughput is set by the single decode step between input and result register
// a stalled result holds the decoder only for bytes that make a result
// rst_n is synchronous; reset clears the escape, receive and count state

module dle_frame_receiver_top
  import dfr_pkg::*;
(
  input  wire logic       clk,
  input  wire logic       rst_n,
  input  wire logic       in_valid,
  output logic            in_ready,
  input  wire logic [7:0] in_rx_byte,
  output logic            out_valid,
  input  wire logic       out_ready,
  output logic [1:0]      out_event_kind,
  output logic [7:0]      out_payload_byte,
  output logic [7:0]      out_position
);

  logic        take;
  logic        s1_valid;
  logic [7:0]  s1_byte;
  logic        out_free;
  logic        res_valid;
  dfr_result_t res;

  // input register
  dfr_in_stage u_in (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_valid   (in_valid),
    .in_ready   (in_ready),
    .in_rx_byte (in_rx_byte),
    .take       (take),
    .s1_valid   (s1_valid),
    .s1_byte    (s1_byte)
  );

  // framing decode and state
  dfr_decoder u_dec (
    .clk       (clk),
    .rst_n     (rst_n),
    .s1_valid  (s1_valid),
    .s1_byte   (s1_byte),
    .out_free  (out_free),
    .take      (take),
    .res_valid (res_valid),
    .res       (res)
  );

  // result register
  dfr_out_reg u_out (
    .clk              (clk),
    .rst_n            (rst_n),
    .res_valid        (res_valid),
    .res              (res),
    .out_free         (out_free),
    .out_valid        (out_valid),
    .out_ready        (out_ready),
    .out_event_kind   (out_event_kind),
    .out_payload_byte (out_payload_byte),
    .out_position     (out_position)
  );

endmodule

`default_nettype wire
